>>> hw/rtl/sirt_pkg.sv
// shared types, constants and a saturating add helper for the sir tick block
package sirt_pkg;

  localparam int VW = 48;
  localparam int FB = 24;
  localparam int NW = VW + 2;
  localparam int CW = 48;
  localparam int IDXW = 3;

  localparam logic [IDXW-1:0] CFG_INIT_S = 3'd0;
  localparam logic [IDXW-1:0] CFG_INIT_I = 3'd1;
  localparam logic [IDXW-1:0] CFG_INIT_R = 3'd2;
  localparam logic [IDXW-1:0] CFG_BETA   = 3'd3;
  localparam logic [IDXW-1:0] CFG_GAMMA  = 3'd4;
  localparam logic [IDXW-1:0] CFG_DT     = 3'd5;
  localparam logic [IDXW-1:0] CFG_PERIOD = 3'd6;

  // exp(-1) in q32 built from the squared half-argument series
  localparam logic [63:0] EXP_ONE  = 64'd1 << 32;
  localparam logic [63:0] HT1      = (EXP_ONE >> 1) / 64'd1;
  localparam logic [63:0] HT2      = (HT1 >> 1) / 64'd2;
  localparam logic [63:0] HT3      = (HT2 >> 1) / 64'd3;
  localparam logic [63:0] HT4      = (HT3 >> 1) / 64'd4;
  localparam logic [63:0] HT5      = (HT4 >> 1) / 64'd5;
  localparam logic [63:0] HT6      = (HT5 >> 1) / 64'd6;
  localparam logic [63:0] HT7      = (HT6 >> 1) / 64'd7;
  localparam logic [63:0] HT8      = (HT7 >> 1) / 64'd8;
  localparam logic [63:0] HT9      = (HT8 >> 1) / 64'd9;
  localparam logic [63:0] HT10     = (HT9 >> 1) / 64'd10;
  localparam logic [63:0] HT11     = (HT10 >> 1) / 64'd11;
  localparam logic [63:0] HT12     = (HT11 >> 1) / 64'd12;
  localparam logic [63:0] HT13     = (HT12 >> 1) / 64'd13;
  localparam logic [63:0] EXP_HALF = EXP_ONE - HT1 + HT2 - HT3 + HT4 - HT5 + HT6 - HT7
                                     + HT8 - HT9 + HT10 - HT11 + HT12 - HT13;
  localparam logic [63:0] EXP_SQ   = (EXP_HALF * EXP_HALF) >> 32;
  localparam logic [31:0] EXP_C1   = EXP_SQ[31:0];

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_DIV, ST_BQ, ST_P, ST_G, ST_EXPI, ST_SMUL,
    ST_SACC, ST_POW, ST_MLO, ST_MHI, ST_MOD, ST_UPD, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_CAPTURE, CMD_SUM, CMD_DIV, CMD_BQ, CMD_P,
    CMD_G, CMD_EXPI, CMD_SMUL, CMD_SACC, CMD_POW, CMD_MLO, CMD_MHI,
    CMD_MOD, CMD_UPD, CMD_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   sel_inf;
  } cmd_t;

  typedef struct packed {
    logic pop_zero;
    logic n_eq_i;
    logic div_last;
    logic ser_last;
    logic pow_done;
    logic mod_last;
  } sts_t;

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a,
                                            input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VW] ? {VW{1'b1}} : s[VW-1:0];
  endfunction

endpackage

>>> hw/rtl/sirt_ctrl.sv
// sequencer for the sir tick: issues datapath commands, owns output valid
module sirt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           mode_i,
  input  logic           out_stall_i,
  input  sirt_pkg::sts_t sts_i,
  output sirt_pkg::cmd_t cmd_o,
  output logic           in_stall_o,
  output logic           out_valid_o
);

  sirt_pkg::state_e state_q, state_d;
  logic phase_q, phase_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sirt_pkg::ST_IDLE;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = sirt_pkg::CMD_NONE;
    cmd_o.sel_inf = !phase_q;
    unique case (state_q)
      sirt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!mode_i) begin
            cmd_o.op = sirt_pkg::CMD_LOAD;
            state_d  = sirt_pkg::ST_DONE;
          end else begin
            cmd_o.op = sirt_pkg::CMD_CAPTURE;
            state_d  = sirt_pkg::ST_SUM;
          end
        end
      end
      sirt_pkg::ST_SUM: begin
        cmd_o.op = sirt_pkg::CMD_SUM;
        phase_d  = 1'b0;
        if (sts_i.pop_zero) state_d = sirt_pkg::ST_G;
        else if (sts_i.n_eq_i) state_d = sirt_pkg::ST_BQ;
        else state_d = sirt_pkg::ST_DIV;
      end
      sirt_pkg::ST_DIV: begin
        cmd_o.op = sirt_pkg::CMD_DIV;
        if (sts_i.div_last) state_d = sirt_pkg::ST_BQ;
      end
      sirt_pkg::ST_BQ: begin
        cmd_o.op = sirt_pkg::CMD_BQ;
        state_d  = sirt_pkg::ST_P;
      end
      sirt_pkg::ST_P: begin
        cmd_o.op = sirt_pkg::CMD_P;
        state_d  = sirt_pkg::ST_EXPI;
      end
      sirt_pkg::ST_G: begin
        cmd_o.op = sirt_pkg::CMD_G;
        phase_d  = 1'b1;
        state_d  = sirt_pkg::ST_EXPI;
      end
      sirt_pkg::ST_EXPI: begin
        cmd_o.op = sirt_pkg::CMD_EXPI;
        state_d  = sirt_pkg::ST_SMUL;
      end
      sirt_pkg::ST_SMUL: begin
        cmd_o.op = sirt_pkg::CMD_SMUL;
        state_d  = sirt_pkg::ST_SACC;
      end
      sirt_pkg::ST_SACC: begin
        cmd_o.op = sirt_pkg::CMD_SACC;
        state_d  = sts_i.ser_last ? sirt_pkg::ST_POW : sirt_pkg::ST_SMUL;
      end
      sirt_pkg::ST_POW: begin
        if (sts_i.pow_done) state_d = sirt_pkg::ST_MLO;
        else cmd_o.op = sirt_pkg::CMD_POW;
      end
      sirt_pkg::ST_MLO: begin
        cmd_o.op = sirt_pkg::CMD_MLO;
        state_d  = sirt_pkg::ST_MHI;
      end
      sirt_pkg::ST_MHI: begin
        cmd_o.op = sirt_pkg::CMD_MHI;
        state_d  = phase_q ? sirt_pkg::ST_MOD : sirt_pkg::ST_G;
      end
      sirt_pkg::ST_MOD: begin
        cmd_o.op = sirt_pkg::CMD_MOD;
        if (sts_i.mod_last) state_d = sirt_pkg::ST_UPD;
      end
      sirt_pkg::ST_UPD: begin
        cmd_o.op = sirt_pkg::CMD_UPD;
        state_d  = sirt_pkg::ST_DONE;
      end
      sirt_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.op    = sirt_pkg::CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = sirt_pkg::ST_IDLE;
        end
      end
      default: state_d = sirt_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != sirt_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hw/rtl/sirt_dp.sv
// datapath for the sir tick: config, state, divider, exp series, modulo
module sirt_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [sirt_pkg::IDXW-1:0] cfg_index_i,
  input  logic [sirt_pkg::CW-1:0]   cfg_data_i,
  input  logic [31:0]               tick_time_i,
  input  sirt_pkg::cmd_t            cmd_i,
  output sirt_pkg::sts_t            sts_o,
  output logic [47:0]               susceptible_o,
  output logic [47:0]               infected_o,
  output logic [47:0]               recovered_o,
  output logic [47:0]               cases_cumulative_o,
  output logic [47:0]               cases_window_o,
  output logic                      population_zero_o
);

  localparam int VW = sirt_pkg::VW;
  localparam int FB = sirt_pkg::FB;
  localparam int NW = sirt_pkg::NW;
  localparam logic [31:0] C1 = sirt_pkg::EXP_C1;
  localparam logic [32:0] ONE32 = 33'h1_0000_0000;

  // rounded-up reciprocals scaled by 2^36, exact for terms below 2^32
  localparam logic [63:0] RCP_ONE = 64'd1 << 36;
  localparam logic [35:0] RCP2  = 36'((RCP_ONE + 64'd1) / 64'd2);
  localparam logic [35:0] RCP3  = 36'((RCP_ONE + 64'd2) / 64'd3);
  localparam logic [35:0] RCP4  = 36'((RCP_ONE + 64'd3) / 64'd4);
  localparam logic [35:0] RCP5  = 36'((RCP_ONE + 64'd4) / 64'd5);
  localparam logic [35:0] RCP6  = 36'((RCP_ONE + 64'd5) / 64'd6);
  localparam logic [35:0] RCP7  = 36'((RCP_ONE + 64'd6) / 64'd7);
  localparam logic [35:0] RCP8  = 36'((RCP_ONE + 64'd7) / 64'd8);
  localparam logic [35:0] RCP9  = 36'((RCP_ONE + 64'd8) / 64'd9);
  localparam logic [35:0] RCP10 = 36'((RCP_ONE + 64'd9) / 64'd10);
  localparam logic [35:0] RCP11 = 36'((RCP_ONE + 64'd10) / 64'd11);
  localparam logic [35:0] RCP12 = 36'((RCP_ONE + 64'd11) / 64'd12);
  localparam logic [35:0] RCP13 = 36'((RCP_ONE + 64'd12) / 64'd13);

  logic [47:0] init_s_q, init_i_q, init_r_q;
  logic [27:0] beta_q, gamma_q;
  logic [24:0] dt_q;
  logic [15:0] period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_s_q <= 48'd16777216000;
      init_i_q <= 48'd167772160;
      init_r_q <= 48'd0;
      beta_q   <= 28'd3355443;
      gamma_q  <= 28'd1677722;
      dt_q     <= 25'd4194304;
      period_q <= 16'd4;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sirt_pkg::CFG_INIT_S: init_s_q <= cfg_data_i[47:0];
        sirt_pkg::CFG_INIT_I: init_i_q <= cfg_data_i[47:0];
        sirt_pkg::CFG_INIT_R: init_r_q <= cfg_data_i[47:0];
        sirt_pkg::CFG_BETA:   beta_q   <= cfg_data_i[27:0];
        sirt_pkg::CFG_GAMMA:  gamma_q  <= cfg_data_i[27:0];
        sirt_pkg::CFG_DT:     dt_q     <= cfg_data_i[24:0];
        sirt_pkg::CFG_PERIOD: period_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [VW-1:0] s_q, i_q, r_q, cum_q, win_q;
  logic [NW-1:0] n_q, rem_q;
  logic [FB:0]   q_q;
  logic [28:0]   bq_q;
  logic [29:0]   x_q;
  logic [31:0]   f_q, tt_q;
  logic [32:0]   term_q, tp_q, sum_q, mlo_q;
  logic [3:0]    k_q;
  logic [6:0]    cnt_q, nint_q;
  logic [16:0]   mrem_q;
  logic [VW-1:0] nsi_q, nir_q;
  logic          zflag_q;
  logic [47:0]   o_s_q, o_i_q, o_r_q, o_c_q, o_w_q;
  logic          o_z_q;

  logic [NW:0]   div_sh;
  logic [52:0]   bq_prod;
  logic [53:0]   p_prod;
  logic [52:0]   g_prod;
  logic [64:0]   ser_prod, pow_prod, lo_prod;
  logic [32:0]   term_d, sum_d;
  logic [35:0]   rcp;
  logic          use_rcp;
  logic [68:0]   rcp_prod;
  logic [VW-1:0] opa;
  logic [32:0]   omb;
  logic [48:0]   hi_res;
  logic [15:0]   per;
  logic [16:0]   mod_sh;

  assign div_sh  = {rem_q, 1'b0};
  assign bq_prod = 53'(beta_q) * 53'(q_q);
  assign p_prod  = 54'(bq_q) * 54'(dt_q);
  assign g_prod  = 53'(gamma_q) * 53'(dt_q);
  assign ser_prod = 65'(term_q) * 65'(f_q);
  assign pow_prod = 65'(sum_q) * 65'(C1);
  assign opa     = cmd_i.sel_inf ? s_q : i_q;
  assign omb     = ONE32 - sum_q;
  assign lo_prod = 65'(opa[31:0]) * 65'(omb);
  assign hi_res  = 49'(opa[VW-1:32]) * 49'(omb) + {16'd0, mlo_q};
  assign per     = (period_q == 16'd0) ? 16'd1 : period_q;
  assign mod_sh  = {mrem_q[15:0], tt_q[5'd31 - cnt_q[4:0]]};
  assign rcp_prod = 69'(tp_q) * 69'(rcp);

  // term divided by the step index through a fixed reciprocal
  always_comb begin
    rcp     = '0;
    use_rcp = 1'b1;
    case (k_q)
      4'd2:    rcp = RCP2;
      4'd3:    rcp = RCP3;
      4'd4:    rcp = RCP4;
      4'd5:    rcp = RCP5;
      4'd6:    rcp = RCP6;
      4'd7:    rcp = RCP7;
      4'd8:    rcp = RCP8;
      4'd9:    rcp = RCP9;
      4'd10:   rcp = RCP10;
      4'd11:   rcp = RCP11;
      4'd12:   rcp = RCP12;
      4'd13:   rcp = RCP13;
      default: use_rcp = 1'b0;
    endcase
  end

  always_comb begin
    term_d = use_rcp ? rcp_prod[68:36] : tp_q;
    if (k_q[0]) sum_d = (term_d > sum_q) ? 33'd0 : sum_q - term_d;
    else sum_d = sum_q + term_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= 48'd16777216000;
      i_q   <= 48'd167772160;
      r_q   <= '0;
      cum_q <= '0;
      win_q <= '0;
    end else begin
      unique case (cmd_i.op)
        sirt_pkg::CMD_LOAD: begin
          s_q   <= init_s_q;
          i_q   <= init_i_q;
          r_q   <= init_r_q;
          cum_q <= '0;
          win_q <= '0;
        end
        sirt_pkg::CMD_UPD: begin
          s_q   <= s_q - nsi_q;
          i_q   <= sirt_pkg::sat_add(i_q - nir_q, nsi_q);
          r_q   <= sirt_pkg::sat_add(r_q, nir_q);
          cum_q <= sirt_pkg::sat_add(cum_q, nsi_q);
          win_q <= (mrem_q == 17'd0) ? nsi_q : sirt_pkg::sat_add(win_q, nsi_q);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      sirt_pkg::CMD_LOAD: zflag_q <= 1'b0;
      sirt_pkg::CMD_CAPTURE: tt_q <= tick_time_i;
      sirt_pkg::CMD_SUM: begin
        n_q     <= {2'b00, s_q} + {2'b00, i_q} + {2'b00, r_q};
        rem_q   <= {2'b00, i_q};
        q_q     <= sts_o.n_eq_i ? (FB+1)'(1) << FB : '0;
        zflag_q <= sts_o.pop_zero;
        nsi_q   <= '0;
        cnt_q   <= '0;
      end
      sirt_pkg::CMD_DIV: begin
        if (div_sh >= {1'b0, n_q}) begin
          rem_q <= NW'(div_sh - {1'b0, n_q});
          q_q   <= {q_q[FB-1:0], 1'b1};
        end else begin
          rem_q <= div_sh[NW-1:0];
          q_q   <= {q_q[FB-1:0], 1'b0};
        end
        cnt_q <= cnt_q + 7'd1;
      end
      sirt_pkg::CMD_BQ: bq_q <= bq_prod[52:24];
      sirt_pkg::CMD_P:  x_q  <= p_prod[53:24];
      sirt_pkg::CMD_G: begin
        x_q    <= {1'b0, g_prod[52:24]};
        mrem_q <= '0;
      end
      sirt_pkg::CMD_EXPI: begin
        nint_q <= {1'b0, x_q[29:24]};
        f_q    <= {x_q[23:0], 8'd0};
        term_q <= ONE32;
        sum_q  <= ONE32;
        k_q    <= 4'd1;
        cnt_q  <= '0;
      end
      sirt_pkg::CMD_SMUL: tp_q <= ser_prod[64:32];
      sirt_pkg::CMD_SACC: begin
        term_q <= term_d;
        sum_q  <= sum_d;
        k_q    <= k_q + 4'd1;
      end
      sirt_pkg::CMD_POW: begin
        sum_q <= pow_prod[64:32];
        cnt_q <= cnt_q + 7'd1;
      end
      sirt_pkg::CMD_MLO: mlo_q <= lo_prod[64:32];
      sirt_pkg::CMD_MHI: begin
        if (cmd_i.sel_inf) nsi_q <= hi_res[47:0];
        else nir_q <= hi_res[47:0];
        cnt_q <= '0;
      end
      sirt_pkg::CMD_MOD: begin
        mrem_q <= (mod_sh >= {1'b0, per}) ? mod_sh - {1'b0, per} : mod_sh;
        cnt_q  <= cnt_q + 7'd1;
      end
      sirt_pkg::CMD_OUT: begin
        o_s_q <= s_q;
        o_i_q <= i_q;
        o_r_q <= r_q;
        o_c_q <= cum_q;
        o_w_q <= win_q;
        o_z_q <= zflag_q;
      end
      default: ;
    endcase
  end

  assign sts_o.pop_zero = (s_q == '0) && (i_q == '0) && (r_q == '0);
  assign sts_o.n_eq_i   = (s_q == '0) && (r_q == '0);
  assign sts_o.div_last = (cnt_q == 7'(FB - 1));
  assign sts_o.ser_last = (k_q == 4'd13);
  assign sts_o.pow_done = (cnt_q == nint_q);
  assign sts_o.mod_last = (cnt_q == 7'd31);

  assign susceptible_o      = o_s_q;
  assign infected_o         = o_i_q;
  assign recovered_o        = o_r_q;
  assign cases_cumulative_o = o_c_q;
  assign cases_window_o     = o_w_q;
  assign population_zero_o  = o_z_q;

endmodule

>>> hw/rtl/sir_model_tick_top.sv
// sequence: a load word goes to the done state; a tick word runs a 24-step divide, two 13-term
// exp series (multiply and accumulate per term), a power step per whole unit of each exponent and
// a 32-step modulo; an empty population skips the divide and first series, infected-only the divide
// throughput: one word at a time, the next is taken once the result is in the output register
// reset: asynchronous active low; config and state return to their default values
module sir_model_tick_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic [31:0] tick_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [47:0] susceptible_o,
  output logic [47:0] infected_o,
  output logic [47:0] recovered_o,
  output logic [47:0] cases_cumulative_o,
  output logic [47:0] cases_window_o,
  output logic        population_zero_o
);

  sirt_pkg::cmd_t cmd;
  sirt_pkg::sts_t sts;

  sirt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  sirt_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .tick_time_i       (tick_time_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .susceptible_o     (susceptible_o),
    .infected_o        (infected_o),
    .recovered_o       (recovered_o),
    .cases_cumulative_o(cases_cumulative_o),
    .cases_window_o    (cases_window_o),
    .population_zero_o (population_zero_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after taking a word");

  a_zero_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && population_zero_o) |->
      (susceptible_o == 48'd0 && infected_o == 48'd0 && recovered_o == 48'd0))
    else $error("population flag with nonzero compartments");

  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a word in flight");

endmodule

>>> dv/tb.sv
// testbench for the sir tick block: predicts each result and checks every output word
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [47:0] ALL_ONES = {48{1'b1}};
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic [47:0] s;
    logic [47:0] i;
    logic [47:0] r;
    logic [47:0] cum;
    logic [47:0] win;
    logic        pz;
  } sir_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        mode_i = 1'b0;
  logic [31:0] tick_time_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [47:0] susceptible_o, infected_o, recovered_o, cases_cumulative_o, cases_window_o;
  logic        population_zero_o;

  sir_model_tick_top u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // model copy of config and state
  logic [47:0] m_init_s, m_init_i, m_init_r;
  logic [27:0] m_beta, m_gamma;
  logic [24:0] m_dt;
  logic [15:0] m_period;
  logic [47:0] m_s, m_i, m_r, m_cum, m_win;

  sir_word_t expected_words[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;
  bit  hold_go = 1'b0;
  int  quiet_cycles = 0;

  function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
    logic [48:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[48] ? ALL_ONES : t[47:0];
  endfunction

  // exp(-y) in q32 by alternating taylor series, y below one
  function automatic logic [63:0] taylor_exp(logic [63:0] y);
    logic [63:0] acc, term;
    acc = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * y) >> 32) / k;
      if (k % 2 == 1) acc = (term > acc) ? 64'd0 : acc - term;
      else acc = acc + term;
    end
    return acc;
  endfunction

  function automatic logic [63:0] decay_q32(logic [63:0] x);
    logic [63:0] whole, r, c, c1;
    whole = x >> 24;
    r = taylor_exp({x[23:0], 8'd0});
    c = taylor_exp(64'd1 << 31);
    c1 = (c * c) >> 32;
    if (whole > 64) whole = 64;
    for (int n = 0; n < whole; n++) r = (r * c1) >> 32;
    return r;
  endfunction

  function automatic logic [47:0] scale_q32(logic [47:0] a, logic [63:0] b);
    logic [127:0] t;
    t = ({80'd0, a} * {64'd0, b}) >> 32;
    return t[47:0];
  endfunction

  function automatic sir_word_t advance_epidemic(logic mode, logic [31:0] t);
    sir_word_t w;
    logic [127:0] pop, frac;
    logic [63:0] bq, p, g;
    logic [47:0] n_si, n_ir, s0, i0, r0;
    logic [15:0] per;
    w.pz = 1'b0;
    if (mode == MODE_LOAD) begin
      m_s = m_init_s; m_i = m_init_i; m_r = m_init_r; m_cum = '0; m_win = '0;
    end else begin
      s0 = m_s; i0 = m_i; r0 = m_r;
      pop = {80'd0, s0} + {80'd0, i0} + {80'd0, r0};
      n_si = '0;
      if (pop == 0) w.pz = 1'b1;
      else begin
        frac = ({80'd0, i0} << 24) / pop;
        bq = ({36'd0, m_beta} * frac[63:0]) >> 24;
        p = (bq * {39'd0, m_dt}) >> 24;
        n_si = scale_q32(s0, (64'd1 << 32) - decay_q32(p));
      end
      g = ({36'd0, m_gamma} * {39'd0, m_dt}) >> 24;
      n_ir = scale_q32(i0, (64'd1 << 32) - decay_q32(g));
      m_s = s0 - n_si;
      m_i = add_sat(i0 - n_ir, n_si);
      m_r = add_sat(r0, n_ir);
      m_cum = add_sat(m_cum, n_si);
      per = (m_period == 0) ? 16'd1 : m_period;
      if (t % per == 0) m_win = n_si;
      else m_win = add_sat(m_win, n_si);
    end
    w.s = m_s; w.i = m_i; w.r = m_r; w.cum = m_cum; w.win = m_win;
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o)
      expected_words = {expected_words, advance_epidemic(mode_i, tick_time_i)};
  end

  task automatic report_field(string name, logic [47:0] e, logic [47:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    sir_word_t e;
    if (out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word expected none actual s=%h", $time, susceptible_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        report_field("susceptible", e.s, susceptible_o);
        report_field("infected", e.i, infected_o);
        report_field("recovered", e.r, recovered_o);
        report_field("cases_cumulative", e.cum, cases_cumulative_o);
        report_field("cases_window", e.win, cases_window_o);
        report_field("population_zero", {47'd0, e.pz}, {47'd0, population_zero_o});
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left <= 1500;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(logic mode, logic [31:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    tick_time_i <= t;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (expected_words.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic program_model(logic [47:0] s, logic [47:0] i, logic [47:0] r,
                               logic [27:0] b, logic [27:0] g, logic [24:0] dt,
                               logic [15:0] per);
    logic [47:0] vals[7];
    drain();
    vals = '{s, i, r, {20'd0, b}, {20'd0, g}, {23'd0, dt}, {32'd0, per}};
    for (int k = 0; k < 7; k++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= k[2:0];
      cfg_data_i <= vals[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    m_init_s = s; m_init_i = i; m_init_r = r;
    m_beta = b; m_gamma = g; m_dt = dt; m_period = per;
  endtask

  function automatic logic [47:0] rand_count();
    logic [47:0] v;
    v = 48'({$urandom, $urandom});
    return v >> $urandom_range(47);
  endfunction

  task automatic test_defaults();
    send_word(MODE_TICK, 32'd0);
    send_word(MODE_TICK, 32'd1);
    send_word(MODE_LOAD, 32'd0);
    for (int k = 0; k < 5; k++) send_word(MODE_TICK, k);
  endtask

  task automatic test_population_zero();
    program_model('0, '0, '0, 28'hFFFFFFF, 28'hFFFFFFF, 25'h1000000, 16'd0);
    send_word(MODE_LOAD, '1);
    send_word(MODE_TICK, '1);
    send_word(MODE_TICK, 32'd7);
  endtask

  task automatic test_saturation();
    program_model(ALL_ONES, ALL_ONES, ALL_ONES, 28'hFFFFFFF, 28'hFFFFFFF,
                  25'h1000000, 16'hFFFF);
    send_word(MODE_LOAD, '0);
    for (int k = 0; k < 4; k++) send_word(MODE_TICK, 32'hFFFF_FFFF - k);
    program_model(ALL_ONES, 48'd1, '0, '0, '0, '0, 16'd1);
    send_word(MODE_LOAD, '0);
    send_word(MODE_TICK, 32'd3);
  endtask

  task automatic test_random(int idle, int stall, int count, bit hold);
    logic [15:0] per;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        per = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
        program_model(rand_count(), rand_count(), rand_count(), 28'($urandom),
                      28'($urandom >> $urandom_range(27)),
                      25'($urandom_range(32'h1000000)), per);
        send_word(MODE_LOAD, $urandom);
      end
      if (hold && n == 30) hold_go = 1'b1;
      if ($urandom_range(9) == 0) send_word(MODE_LOAD, $urandom);
      else send_word(MODE_TICK, ($urandom_range(1) == 0) ? $urandom : 32'(n));
    end
    drain();
  endtask

  initial begin
    m_init_s = 48'd16777216000; m_init_i = 48'd167772160; m_init_r = '0;
    m_beta = 28'd3355443; m_gamma = 28'd1677722; m_dt = 25'd4194304; m_period = 16'd4;
    m_s = m_init_s; m_i = m_init_i; m_r = m_init_r; m_cum = '0; m_win = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_population_zero();
    test_saturation();
    test_random(0, 0, 350, 1'b1);
    test_random(73, 0, 350, 1'b0);
    test_random(0, 73, 350, 1'b0);
    test_random(12, 12, 350, 1'b1);
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
